>>> hdl/pcdp_pkg.sv
`timescale 1ns / 1ps
package pcdp_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VA_W = $clog2(MAX_VERTICES);
	localparam int VC_W = $clog2(MAX_VERTICES + 1);

	// Shared multiplier: A x B, B taken in MB_CHUNK-bit slices.
	localparam int MA_W = 66;
	localparam int MB_CHUNK = 12;
	localparam int MB_SLICES = 3;
	localparam int MB_W = MB_CHUNK * MB_SLICES;
	localparam int MP_W = MA_W + MB_W;

	localparam logic [16:0] DIST_MAX = 17'h1FFFF;
	localparam logic [11:0] MARGIN_RST = 12'd320;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef enum logic [2:0] {PR_NONE, PR_UU, PR_UV, PR_CR, PR_VV, PR_WW} pair_t;
	typedef enum logic [1:0] {MS_CR, MS_X, MS_Y, MS_ROOT} msel_t;

	typedef struct packed {
		logic            clear;
		logic            append;
		logic            q_start;
		logic            rd_en;
		logic [VA_W-1:0] rd_addr;
		logic            ld_first;
		logic            ld_edge;
		logic            use_first;
		pair_t           pr_sel;
		logic            classify;
		logic            mul_start;
		msel_t           mul_sel;
		logic            take_cr;
		logic            best_set;
		logic            x_save;
		logic            cmp;
		logic            root_init;
		logic            root_sq;
		logic [4:0]      root_bit;
		logic            root_step;
		logic            load_out;
		logic            short_res;
	} dp_cmd_t;

	typedef struct packed {
		logic [VC_W-1:0] count;
		logic            interior;
		logic            mul_done;
	} dp_sts_t;

endpackage

>>> hdl/pcdp_ram.sv
`timescale 1ns / 1ps
module pcdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/pcdp_mul.sv
`timescale 1ns / 1ps
module pcdp_mul import pcdp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MA_W-1:0] a,
	input  logic [MB_W-1:0] b,
	output logic [MP_W-1:0] prod,
	output logic            done
);

	logic [MA_W-1:0] a_q;
	logic [MB_W-1:0] b_q;
	logic [1:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [MP_W-1:0] acc_q;
	logic [MA_W+MB_CHUNK-1:0] pp;
	logic [MP_W-1:0] pp_sh;

	assign pp = a_q * b_q[MB_CHUNK-1:0];

	always_comb begin
		case (cnt_q)
			2'd0:    pp_sh = MP_W'(pp);
			2'd1:    pp_sh = MP_W'(pp) << MB_CHUNK;
			default: pp_sh = MP_W'(pp) << (2 * MB_CHUNK);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'(MB_SLICES - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'(MB_SLICES - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
			b_q   <= b_q >> MB_CHUNK;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

>>> hdl/pcdp_dp.sv
`timescale 1ns / 1ps
module pcdp_dp import pcdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic               margin_we,
	input  logic [11:0]        margin_wdata,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	output logic               inside_res,
	output logic               on_boundary,
	output logic [16:0]        edge_distance,
	output logic [35:0]        penalty,
	output logic [1:0]         status
);

	logic [11:0]     margin_q;
	logic [VC_W-1:0] count_q;
	logic            trunc_q;

	logic [31:0] rdata;
	logic        full;

	logic signed [15:0] px_q, py_q, fx_q, fy_q, prx_q, pry_q;
	logic signed [15:0] ax_q, ay_q, bx_q, by_q;
	logic signed [15:0] cx, cy;
	logic signed [16:0] ux, uy, vx, vy, wx, wy;
	logic signed [16:0] m1a, m1b, m2a, m2b;
	logic signed [33:0] p1_s1, p2_s1;
	pair_t              tag_s1;
	logic signed [34:0] psum, pdif;
	logic signed [34:0] len2_q, t_q, cr_q, na_q, nb_q;
	logic [33:0]        cr_abs;

	logic            cross_q, bnd_q;
	logic [MA_W-1:0] num_q, bnum_q;
	logic [33:0]     den_q, bden_q;
	logic [MP_W-1:0] x_q;

	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [MP_W-1:0] prod;
	logic            mul_done;

	logic [17:0] d_q, c_q, c_next;
	logic [18:0] t_odd;
	logic [37:0] tsq_q;

	logic [16:0] dist_c;
	logic        inside_c;
	logic [17:0] pbase;
	logic        seg_in, s_pos, s_zero;
	logic signed [15:0] lo_x, hi_x, lo_y, hi_y;

	assign full = (count_q == VC_W'(MAX_VERTICES));

	pcdp_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram (
		.clk   (clk),
		.we    (cmd.append && !full),
		.waddr (count_q[VA_W-1:0]),
		.wdata ({vertex_x, vertex_y}),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
			count_q  <= '0;
			trunc_q  <= 1'b0;
		end else begin
			if (margin_we) begin
				margin_q <= margin_wdata;
			end
			if (cmd.clear) begin
				count_q <= '0;
				trunc_q <= 1'b0;
			end else if (cmd.append) begin
				if (full) begin
					trunc_q <= 1'b1;
				end else begin
					count_q <= count_q + VC_W'(1);
				end
			end
		end
	end

	// edge endpoints
	assign cx = cmd.use_first ? fx_q : signed'(rdata[31:16]);
	assign cy = cmd.use_first ? fy_q : signed'(rdata[15:0]);

	assign ux = 17'(bx_q) - 17'(ax_q);
	assign uy = 17'(by_q) - 17'(ay_q);
	assign vx = 17'(px_q) - 17'(ax_q);
	assign vy = 17'(py_q) - 17'(ay_q);
	assign wx = 17'(px_q) - 17'(bx_q);
	assign wy = 17'(py_q) - 17'(by_q);

	always_comb begin
		case (cmd.pr_sel)
			PR_UU:   begin m1a = ux; m1b = ux; m2a = uy; m2b = uy; end
			PR_UV:   begin m1a = ux; m1b = vx; m2a = uy; m2b = vy; end
			PR_CR:   begin m1a = ux; m1b = vy; m2a = uy; m2b = vx; end
			PR_VV:   begin m1a = vx; m1b = vx; m2a = vy; m2b = vy; end
			PR_WW:   begin m1a = wx; m1b = wx; m2a = wy; m2b = wy; end
			default: begin m1a = '0; m1b = '0; m2a = '0; m2b = '0; end
		endcase
	end

	assign psum = 35'(p1_s1) + 35'(p2_s1);
	assign pdif = 35'(p1_s1) - 35'(p2_s1);
	assign cr_abs = cr_q[34] ? 34'(-cr_q) : 34'(cr_q);

	assign sts.count    = count_q;
	assign sts.interior = (t_q > 35'sd0) && (t_q < len2_q);
	assign sts.mul_done = mul_done;

	// crossing test, s is the negated cross product
	assign lo_x = (ax_q < bx_q) ? ax_q : bx_q;
	assign hi_x = (ax_q < bx_q) ? bx_q : ax_q;
	assign lo_y = (ay_q < by_q) ? ay_q : by_q;
	assign hi_y = (ay_q < by_q) ? by_q : ay_q;
	assign seg_in = (lo_x < px_q) && (px_q < hi_x);
	assign s_pos  = (bx_q < ax_q) ? (cr_q > 35'sd0) : (cr_q < 35'sd0);
	assign s_zero = (cr_q == 35'sd0);

	always_comb begin
		case (cmd.mul_sel)
			MS_CR:   begin mul_a = MA_W'(cr_abs); mul_b = MB_W'(cr_abs); end
			MS_X:    begin mul_a = num_q;         mul_b = MB_W'(bden_q); end
			MS_Y:    begin mul_a = bnum_q;        mul_b = MB_W'(den_q);  end
			default: begin mul_a = MA_W'(tsq_q);  mul_b = MB_W'(bden_q); end
		endcase
	end

	pcdp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.done   (mul_done)
	);

	assign c_next = d_q | (18'd1 << cmd.root_bit);
	assign t_odd  = {c_next, 1'b0} - 19'd1;

	assign dist_c   = (d_q > 18'(DIST_MAX)) ? DIST_MAX : d_q[16:0];
	assign inside_c = !bnd_q && cross_q;
	always_comb begin
		if (!inside_c) begin
			pbase = 18'(dist_c) + 18'(margin_q);
		end else if (dist_c < 17'(margin_q)) begin
			pbase = 18'(margin_q) - 18'(dist_c);
		end else begin
			pbase = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= PR_NONE;
		end else begin
			tag_s1 <= cmd.pr_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			px_q    <= point_x;
			py_q    <= point_y;
			cross_q <= 1'b0;
			bnd_q   <= 1'b0;
		end
		if (cmd.ld_first) begin
			fx_q  <= signed'(rdata[31:16]);
			fy_q  <= signed'(rdata[15:0]);
			prx_q <= signed'(rdata[31:16]);
			pry_q <= signed'(rdata[15:0]);
		end
		if (cmd.ld_edge) begin
			ax_q  <= prx_q;
			ay_q  <= pry_q;
			bx_q  <= cx;
			by_q  <= cy;
			prx_q <= cx;
			pry_q <= cy;
		end
		p1_s1 <= m1a * m1b;
		p2_s1 <= m2a * m2b;
		case (tag_s1)
			PR_UU:   len2_q <= psum;
			PR_UV:   t_q    <= psum;
			PR_CR:   cr_q   <= pdif;
			PR_VV:   na_q   <= psum;
			PR_WW:   nb_q   <= psum;
			default: ;
		endcase
		if (cmd.classify) begin
			if (ax_q != bx_q) begin
				if (seg_in) begin
					if (s_pos) begin
						cross_q <= !cross_q;
					end else if (s_zero) begin
						bnd_q <= 1'b1;
					end
				end else if (px_q == bx_q) begin
					if (py_q < by_q) begin
						if (ax_q > bx_q) begin
							cross_q <= !cross_q;
						end
					end else if (py_q == by_q) begin
						bnd_q <= 1'b1;
					end
				end else if (px_q == ax_q) begin
					if (py_q < ay_q) begin
						if (ax_q < bx_q) begin
							cross_q <= !cross_q;
						end
					end else if (py_q == ay_q) begin
						bnd_q <= 1'b1;
					end
				end
			end else if (px_q == ax_q && lo_y <= py_q && py_q <= hi_y) begin
				bnd_q <= 1'b1;
			end
			if (t_q <= 35'sd0) begin
				num_q <= MA_W'(na_q[33:0]);
				den_q <= 34'd1;
			end else if (t_q >= len2_q) begin
				num_q <= MA_W'(nb_q[33:0]);
				den_q <= 34'd1;
			end else begin
				den_q <= len2_q[33:0];
			end
		end
		if (cmd.take_cr) begin
			num_q <= prod[MA_W-1:0];
		end
		if (cmd.x_save) begin
			x_q <= prod;
		end
		if (cmd.best_set || (cmd.cmp && x_q < prod)) begin
			bnum_q <= num_q;
			bden_q <= den_q;
		end
		if (cmd.root_init) begin
			d_q <= '0;
		end
		if (cmd.root_sq) begin
			c_q   <= c_next;
			tsq_q <= t_odd * t_odd;
		end
		if (cmd.root_step && prod <= MP_W'({bnum_q, 2'b00})) begin
			d_q <= c_q;
		end
		if (cmd.load_out) begin
			if (cmd.short_res) begin
				inside_res    <= 1'b0;
				on_boundary   <= 1'b0;
				edge_distance <= '0;
				penalty       <= '0;
				status        <= ST_SHORT;
			end else begin
				inside_res    <= inside_c;
				on_boundary   <= bnd_q;
				edge_distance <= dist_c;
				penalty       <= pbase * pbase;
				status        <= trunc_q ? ST_TRUNC : ST_OK;
			end
		end
	end

endmodule

>>> hdl/pcdp_ctrl.sv
`timescale 1ns / 1ps
module pcdp_ctrl import pcdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	input  logic [1:0] s_op,
	output logic       s_ready,
	output logic       m_valid,
	input  logic       m_ready,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	typedef enum logic [4:0] {
		IDLE, RD0, LD0, RD, ED, P0, P1, P2, P3, P4, P5, CLS,
		M_CR, W_CR, SETB, M_X, W_X, M_Y, W_Y, NXT,
		R_INIT, R_SQ, R_M, R_W, FIN
	} state_t;

	state_t          state_q;
	logic [VC_W-1:0] idx_q;
	logic [4:0]      bit_q;
	logic            short_q;
	logic            m_valid_q;
	logic            acc;
	logic            out_free;
	logic            first;

	assign s_ready  = (state_q == IDLE);
	assign acc      = s_valid && s_ready;
	assign out_free = !m_valid_q || m_ready;
	assign first    = (idx_q == VC_W'(1));
	assign m_valid  = m_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.pr_sel    = PR_NONE;
		cmd.mul_sel   = MS_CR;
		cmd.rd_addr   = idx_q[VA_W-1:0];
		cmd.root_bit  = bit_q;
		cmd.use_first = (idx_q == sts.count);
		cmd.short_res = short_q;
		case (state_q)
			IDLE: begin
				cmd.clear   = acc && s_op == OP_CLEAR;
				cmd.append  = acc && s_op == OP_APPEND;
				cmd.q_start = acc && s_op == OP_QUERY;
			end
			RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = '0;
			end
			LD0:  cmd.ld_first = 1'b1;
			RD:   cmd.rd_en = 1'b1;
			ED:   cmd.ld_edge = 1'b1;
			P0:   cmd.pr_sel = PR_UU;
			P1:   cmd.pr_sel = PR_UV;
			P2:   cmd.pr_sel = PR_CR;
			P3:   cmd.pr_sel = PR_VV;
			P4:   cmd.pr_sel = PR_WW;
			CLS:  cmd.classify = 1'b1;
			M_CR: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_CR;
			end
			W_CR: cmd.take_cr = sts.mul_done;
			SETB: cmd.best_set = 1'b1;
			M_X: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_X;
			end
			W_X:  cmd.x_save = sts.mul_done;
			M_Y: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_Y;
			end
			W_Y:    cmd.cmp = sts.mul_done;
			R_INIT: cmd.root_init = 1'b1;
			R_SQ:   cmd.root_sq = 1'b1;
			R_M: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_ROOT;
			end
			R_W:  cmd.root_step = sts.mul_done;
			FIN:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			idx_q     <= '0;
			bit_q     <= '0;
			short_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_ready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (acc && s_op == OP_QUERY) begin
						short_q <= (sts.count < VC_W'(3));
						state_q <= (sts.count < VC_W'(3)) ? FIN : RD0;
					end
				end
				RD0: state_q <= LD0;
				LD0: begin
					idx_q   <= VC_W'(1);
					state_q <= RD;
				end
				RD:  state_q <= ED;
				ED:  state_q <= P0;
				P0:  state_q <= P1;
				P1:  state_q <= P2;
				P2:  state_q <= P3;
				P3:  state_q <= P4;
				P4:  state_q <= P5;
				P5:  state_q <= CLS;
				CLS: begin
					if (sts.interior) begin
						state_q <= M_CR;
					end else begin
						state_q <= first ? SETB : M_X;
					end
				end
				M_CR: state_q <= W_CR;
				W_CR: begin
					if (sts.mul_done) begin
						state_q <= first ? SETB : M_X;
					end
				end
				SETB: state_q <= NXT;
				M_X:  state_q <= W_X;
				W_X: begin
					if (sts.mul_done) begin
						state_q <= M_Y;
					end
				end
				M_Y: state_q <= W_Y;
				W_Y: begin
					if (sts.mul_done) begin
						state_q <= NXT;
					end
				end
				NXT: begin
					if (idx_q == sts.count) begin
						state_q <= R_INIT;
					end else begin
						idx_q   <= idx_q + VC_W'(1);
						state_q <= RD;
					end
				end
				R_INIT: begin
					bit_q   <= 5'd17;
					state_q <= R_SQ;
				end
				R_SQ: state_q <= R_M;
				R_M:  state_q <= R_W;
				R_W: begin
					if (sts.mul_done) begin
						if (bit_q == 5'd0) begin
							state_q <= FIN;
						end else begin
							bit_q   <= bit_q - 5'd1;
							state_q <= R_SQ;
						end
					end
				end
				FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> hdl/polygon_containment_distance_penalty.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: vertex_x, vertex_y, point_x, point_y
//                                              tuser: op
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: inside_res, on_boundary,
//                                              edge_distance, penalty; tuser: status
// margin   in   margin_wr_en (no wait)         margin_wr_data
//
// A query walks the stored edges in turn: each edge is loaded, its small products
// are formed and it is classified, then it takes up to three passes through the
// shared 66x36 multiplier (3 slices of 12 bits) and a step to the following edge;
// the first edge needs no compare. The final rounded square root tests 18 bits,
// one multiplier pass per bit.
// A short polygon (under three vertices) answers without walking the edges.
// Reset (arst_n low, asynchronous) empties the polygon and sets margin to 320.
// A finished result waits in the output register; the next item is taken meanwhile,
// but a further query holds at its end until that register is free.
module polygon_containment_distance_penalty import pcdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] vertex_x, [31:16] vertex_y, [47:32] point_x, [63:48] point_y
	input  logic [63:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] inside_res, [1] on_boundary, [18:2] edge_distance, [54:19] penalty, [55] zero
	output logic [55:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]  m_axis_tuser,
	input  logic        margin_wr_en,
	input  logic [11:0] margin_wr_data
);

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic        inside_res;
	logic        on_boundary;
	logic [16:0] edge_distance;
	logic [35:0] penalty;
	logic [1:0]  status;

	// sequence the edge walk, multiplier passes and root search
	pcdp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_op    (s_axis_tuser),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// vertex store, edge arithmetic, crossing count and result register
	pcdp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.margin_we     (margin_wr_en),
		.margin_wdata  (margin_wr_data),
		.vertex_x      (signed'(s_axis_tdata[15:0])),
		.vertex_y      (signed'(s_axis_tdata[31:16])),
		.point_x       (signed'(s_axis_tdata[47:32])),
		.point_y       (signed'(s_axis_tdata[63:48])),
		.inside_res    (inside_res),
		.on_boundary   (on_boundary),
		.edge_distance (edge_distance),
		.penalty       (penalty),
		.status        (status)
	);

	// pack the result, pad to whole bytes
	assign m_axis_tdata = {1'b0, penalty, edge_distance, on_boundary, inside_res};
	assign m_axis_tuser = status;

endmodule
